### rtl/homogeneous_point_transform_defines.svh
// assertion macros shared by the rtl
`ifndef HOMOGENEOUS_POINT_TRANSFORM_DEFINES_SVH
`define HOMOGENEOUS_POINT_TRANSFORM_DEFINES_SVH

// implication checked on every clock edge outside reset
`define HPT_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("hpt assertion failed");

// condition that must hold on every clock edge outside reset
`define HPT_ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("hpt assertion failed");

`endif

### rtl/hpt_pkg.sv
`default_nettype none
package hpt_pkg;

  localparam int FIELD_W  = 32;
  localparam int CFG_W    = 64;
  localparam int NUM_REGS = 8;
  localparam int ADDR_W   = 6;

  // register indexes
  localparam logic [2:0] REG_ROW0_C01 = 3'd0;
  localparam logic [2:0] REG_ROW0_C23 = 3'd1;
  localparam logic [2:0] REG_ROW1_C01 = 3'd2;
  localparam logic [2:0] REG_ROW1_C23 = 3'd3;
  localparam logic [2:0] REG_ROW2_C01 = 3'd4;
  localparam logic [2:0] REG_ROW2_C23 = 3'd5;
  localparam logic [2:0] REG_ROW3_C01 = 3'd6;
  localparam logic [2:0] REG_ROW3_C23 = 3'd7;

  typedef struct packed {
    logic signed [FIELD_W-1:0] point_x;
    logic signed [FIELD_W-1:0] point_y;
    logic signed [FIELD_W-1:0] point_z;
  } hpt_in_t;

  typedef struct packed {
    logic signed [FIELD_W-1:0] out_x;
    logic signed [FIELD_W-1:0] out_y;
    logic signed [FIELD_W-1:0] out_z;
    logic                      zero_w;
  } hpt_out_t;

endpackage
`default_nettype wire

### rtl/homogeneous_point_transform.sv
// throughput: one point per cycle, busy is never raised and the receiver cannot stall
// the latency is set by the 4x4 multiply-add (3 stages) and the bit-per-stage divider
// reset: synchronous active-low rst_n clears the pipeline valid bits and loads
// the identity matrix into the eight matrix registers
`default_nettype none
`include "homogeneous_point_transform_defines.svh"
module homogeneous_point_transform
  import hpt_pkg::*;
#(
  parameter int COORD_WIDTH = 32,
  parameter int FRAC_BITS   = 16
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  input  wire hpt_in_t           in_point,
  output logic                   out_strobe,
  output hpt_out_t               out_result,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [CFG_W-1:0]  pwdata,
  output logic [CFG_W-1:0]       prdata,
  output logic                   pready
);

  localparam int SUM_W   = ((2 * COORD_WIDTH - FRAC_BITS > COORD_WIDTH) ?
                            (2 * COORD_WIDTH - FRAC_BITS) : COORD_WIDTH) + 2;
  localparam int DIV_LAT = COORD_WIDTH + 4;
  localparam int LAT     = DIV_LAT + 3;
  localparam logic [CFG_W-1:0] ONE_LO = CFG_W'(64'(1) << FRAC_BITS);
  localparam logic [CFG_W-1:0] ONE_HI = ONE_LO << 32;
  localparam logic signed [COORD_WIDTH-1:0] MAX_OUT = {1'b0, {(COORD_WIDTH-1){1'b1}}};
  localparam logic signed [COORD_WIDTH-1:0] MIN_OUT = {1'b1, {(COORD_WIDTH-1){1'b0}}};

  logic [CFG_W-1:0] mat_r [NUM_REGS];
  logic [2:0]       reg_idx;
  logic             cfg_wr;
  logic             in_accept;

  logic [LAT-1:0]     valid_r, valid_nxt;
  logic [DIV_LAT-1:0] zw_r;

  logic signed [COORD_WIDTH-1:0] px, py, pz;
  logic signed [COORD_WIDTH-1:0] ent [4][4];
  logic signed [SUM_W-1:0]       rsum [4];
  logic signed [COORD_WIDTH-1:0] res [3];
  logic                          sat_x, sat_z;

  assign busy      = 1'b0;
  assign pready    = 1'b1;
  assign in_accept = start && !busy;

  // configuration registers
  assign reg_idx = paddr[ADDR_W-1:3];
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign prdata  = mat_r[reg_idx];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mat_r[REG_ROW0_C01] <= ONE_LO;
      mat_r[REG_ROW0_C23] <= '0;
      mat_r[REG_ROW1_C01] <= ONE_HI;
      mat_r[REG_ROW1_C23] <= '0;
      mat_r[REG_ROW2_C01] <= '0;
      mat_r[REG_ROW2_C23] <= ONE_LO;
      mat_r[REG_ROW3_C01] <= '0;
      mat_r[REG_ROW3_C23] <= ONE_HI;
    end else if (cfg_wr) begin
      mat_r[reg_idx] <= pwdata;
    end
  end

  // matrix entries from register halves
  always_comb begin
    for (int r = 0; r < 4; r++) begin
      ent[r][0] = mat_r[2*r][COORD_WIDTH-1:0];
      ent[r][1] = mat_r[2*r][32+COORD_WIDTH-1:32];
      ent[r][2] = mat_r[2*r+1][COORD_WIDTH-1:0];
      ent[r][3] = mat_r[2*r+1][32+COORD_WIDTH-1:32];
    end
  end

  assign px = in_point.point_x[COORD_WIDTH-1:0];
  assign py = in_point.point_y[COORD_WIDTH-1:0];
  assign pz = in_point.point_z[COORD_WIDTH-1:0];

  // one multiply-add pipeline per matrix row
  for (genvar r = 0; r < 4; r++) begin : g_row
    hpt_rowsum #(.COORD_WIDTH(COORD_WIDTH), .FRAC_BITS(FRAC_BITS)) u_rowsum (
      .clk (clk),
      .x   (px),
      .y   (py),
      .z   (pz),
      .m0  (ent[r][0]),
      .m1  (ent[r][1]),
      .m2  (ent[r][2]),
      .m3  (ent[r][3]),
      .sum (rsum[r])
    );
  end

  // perspective divide per coordinate
  for (genvar k = 0; k < 3; k++) begin : g_div
    hpt_div_lane #(.COORD_WIDTH(COORD_WIDTH), .FRAC_BITS(FRAC_BITS)) u_div (
      .clk (clk),
      .num (rsum[k]),
      .den (rsum[3]),
      .res (res[k])
    );
  end

  // valid bits travel with the beat
  assign valid_nxt = {valid_r[LAT-2:0], in_accept};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // zero w flag follows the divider
  always_ff @(posedge clk) begin
    zw_r <= {zw_r[DIV_LAT-2:0], (rsum[3] == '0)};
  end

  // result beat
  assign out_strobe = valid_r[LAT-1];
  assign out_result = {FIELD_W'(res[0]), FIELD_W'(res[1]), FIELD_W'(res[2]),
                       zw_r[DIV_LAT-1]};

  // saturated outputs seen on a zero w beat
  assign sat_x = (res[0] == MAX_OUT) || (res[0] == MIN_OUT);
  assign sat_z = (res[2] == MAX_OUT) || (res[2] == MIN_OUT);

  `HPT_ASSERT_IMP(a_strobe_follows_start, out_strobe, $past(in_accept, LAT))
  `HPT_ASSERT_IMP(a_zero_w_sat_x, out_strobe && out_result.zero_w, sat_x)
  `HPT_ASSERT_IMP(a_zero_w_sat_z, out_strobe && out_result.zero_w, sat_z)
  `HPT_ASSERT_ALWAYS(a_never_busy, !busy && pready)

endmodule
`default_nettype wire

### rtl/hpt_rowsum.sv
`default_nettype none
module hpt_rowsum #(
  parameter int COORD_WIDTH = 32,
  parameter int FRAC_BITS   = 16,
  localparam int SUM_W      = ((2 * COORD_WIDTH - FRAC_BITS > COORD_WIDTH) ?
                               (2 * COORD_WIDTH - FRAC_BITS) : COORD_WIDTH) + 2
) (
  input  wire logic                          clk,
  input  wire logic signed [COORD_WIDTH-1:0] x,
  input  wire logic signed [COORD_WIDTH-1:0] y,
  input  wire logic signed [COORD_WIDTH-1:0] z,
  input  wire logic signed [COORD_WIDTH-1:0] m0,
  input  wire logic signed [COORD_WIDTH-1:0] m1,
  input  wire logic signed [COORD_WIDTH-1:0] m2,
  input  wire logic signed [COORD_WIDTH-1:0] m3,
  output logic signed [SUM_W-1:0]            sum
);

  localparam int PROD_W = 2 * COORD_WIDTH;

  logic signed [PROD_W-1:0]      p0_r, p1_r, p2_r;
  logic signed [COORD_WIDTH-1:0] m3_r;
  logic signed [SUM_W-1:0]       a_r, b_r, sum_r;

  // exact products
  always_ff @(posedge clk) begin
    p0_r <= PROD_W'(m0) * PROD_W'(x);
    p1_r <= PROD_W'(m1) * PROD_W'(y);
    p2_r <= PROD_W'(m2) * PROD_W'(z);
    m3_r <= m3;
  end

  // floor to frac bits and pairwise add
  always_ff @(posedge clk) begin
    a_r <= SUM_W'(p0_r >>> FRAC_BITS) + SUM_W'(p1_r >>> FRAC_BITS);
    b_r <= SUM_W'(p2_r >>> FRAC_BITS) + SUM_W'(m3_r);
  end

  // final row sum
  always_ff @(posedge clk) begin
    sum_r <= a_r + b_r;
  end

  assign sum = sum_r;

endmodule
`default_nettype wire

### rtl/hpt_div_lane.sv
`default_nettype none
module hpt_div_lane #(
  parameter int COORD_WIDTH = 32,
  parameter int FRAC_BITS   = 16,
  localparam int SUM_W      = ((2 * COORD_WIDTH - FRAC_BITS > COORD_WIDTH) ?
                               (2 * COORD_WIDTH - FRAC_BITS) : COORD_WIDTH) + 2
) (
  input  wire logic                    clk,
  input  wire logic signed [SUM_W-1:0] num,
  input  wire logic signed [SUM_W-1:0] den,
  output logic signed [COORD_WIDTH-1:0] res
);

  localparam int NS    = COORD_WIDTH + 1;
  localparam int NSH_W = SUM_W + FRAC_BITS;
  localparam int RW    = ((SUM_W > NS) ? SUM_W : NS) + 1;
  localparam logic [NS-1:0] MAXV = NS'((64'(1) << (COORD_WIDTH - 1)) - 64'(1));
  localparam logic [NS-1:0] MINMAG = NS'(64'(1) << (COORD_WIDTH - 1));

  logic [SUM_W-1:0] nmag_r, dmag_r;
  logic             neg0_r;
  logic [NSH_W-1:0] nsh;
  logic [NSH_W-NS-1:0] head;

  logic [RW-1:0]    rem_r [NS+1];
  logic [NS-1:0]    low_r [NS+1];
  logic [NS-1:0]    q_r   [NS+1];
  logic [SUM_W-1:0] d_r   [NS+1];
  logic             neg_r [NS+1];
  logic             ov_r  [NS+1];

  logic [RW-1:0]    trial [NS];
  logic             ge    [NS];
  logic [RW-1:0]    rem_nxt [NS];

  logic [NS-1:0]          q_fin;
  logic                   sat;
  logic [NS-1:0]          mag_neg;
  logic signed [COORD_WIDTH-1:0] res_nxt, res_r;

  // magnitudes and quotient sign
  always_ff @(posedge clk) begin
    nmag_r <= num[SUM_W-1] ? SUM_W'(-num) : SUM_W'(num);
    dmag_r <= den[SUM_W-1] ? SUM_W'(-den) : SUM_W'(den);
    neg0_r <= num[SUM_W-1] ^ den[SUM_W-1];
  end

  // scale numerator, split off high part, overflow when it reaches the divisor
  assign nsh  = {nmag_r, {FRAC_BITS{1'b0}}};
  assign head = nsh[NSH_W-1:NS];

  always_ff @(posedge clk) begin
    rem_r[0] <= RW'(head);
    low_r[0] <= nsh[NS-1:0];
    q_r[0]   <= '0;
    d_r[0]   <= dmag_r;
    neg_r[0] <= neg0_r;
    ov_r[0]  <= RW'(head) >= RW'(dmag_r);
  end

  // one restoring step per stage
  always_comb begin
    for (int k = 0; k < NS; k++) begin
      trial[k]   = {rem_r[k][RW-2:0], low_r[k][NS-1]};
      ge[k]      = trial[k] >= RW'(d_r[k]);
      rem_nxt[k] = ge[k] ? (trial[k] - RW'(d_r[k])) : trial[k];
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < NS; k++) begin
      rem_r[k+1] <= rem_nxt[k];
      low_r[k+1] <= {low_r[k][NS-2:0], 1'b0};
      q_r[k+1]   <= {q_r[k][NS-2:0], ge[k]};
      d_r[k+1]   <= d_r[k];
      neg_r[k+1] <= neg_r[k];
      ov_r[k+1]  <= ov_r[k];
    end
  end

  // saturate and apply sign
  assign q_fin   = q_r[NS];
  assign mag_neg = -q_fin;
  assign sat     = ov_r[NS] || (!neg_r[NS] && (q_fin > MAXV))
                   || (neg_r[NS] && (q_fin > MINMAG));

  always_comb begin
    if (sat) begin
      res_nxt = neg_r[NS] ? COORD_WIDTH'(MINMAG) : COORD_WIDTH'(MAXV);
    end else if (neg_r[NS]) begin
      res_nxt = COORD_WIDTH'(mag_neg);
    end else begin
      res_nxt = COORD_WIDTH'(q_fin);
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  assign res = res_r;

endmodule
`default_nettype wire

### tb/tb_homogeneous_point_transform.sv
`timescale 1ns / 100ps
`default_nettype none
module tb_homogeneous_point_transform
  import hpt_pkg::*;
();

  localparam int LATENCY    = 39;
  localparam int WATCHDOG   = 20000;
  localparam int RAND_ITEMS = 1200;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  hpt_in_t in_point;
  logic out_strobe;
  hpt_out_t out_result;
  logic psel, penable, pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [CFG_W-1:0] pwdata;
  logic [CFG_W-1:0] prdata;
  logic pready;

  homogeneous_point_transform dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_point(in_point),
    .out_strobe(out_strobe), .out_result(out_result), .psel(psel), .penable(penable),
    .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // predictor copy of the matrix registers
  logic [CFG_W-1:0] matrix_regs [NUM_REGS];
  hpt_out_t expected_points [$];
  int fail_count;
  int idle_cycles;
  bit dense_mode;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic longint mat_entry(int row, int col);
    logic [CFG_W-1:0] r;
    logic [31:0] h;
    r = matrix_regs[row * 2 + col / 2];
    h = (col % 2) ? r[63:32] : r[31:0];
    return longint'(signed'(h));
  endfunction

  // product floored to the fraction width (arithmetic shift is a floor)
  function automatic longint dot_row(int row, longint px, longint py, longint pz);
    longint acc;
    acc = mat_entry(row, 3);
    acc += (mat_entry(row, 0) * px) >>> 16;
    acc += (mat_entry(row, 1) * py) >>> 16;
    acc += (mat_entry(row, 2) * pz) >>> 16;
    return acc;
  endfunction

  function automatic logic [31:0] saturating_divide(longint num, longint den);
    longint maxv, minv, q;
    logic [127:0] n, d, qq;
    bit neg;
    maxv = 64'sd2147483647;
    minv = -64'sd2147483648;
    if (den == 0) return (num < 0) ? minv[31:0] : maxv[31:0];
    neg = (num < 0) != (den < 0);
    n = (num < 0) ? 128'(-num) : 128'(num);
    d = (den < 0) ? 128'(-den) : 128'(den);
    qq = (n << 16) / d;
    if (neg) begin
      if (qq > 128'd2147483648) return minv[31:0];
      q = -longint'(qq[63:0]);
      return q[31:0];
    end
    if (qq > 128'd2147483647) return maxv[31:0];
    return qq[31:0];
  endfunction

  function automatic hpt_out_t transform_point(hpt_in_t p);
    hpt_out_t r;
    longint px, py, pz, w;
    px = longint'(p.point_x);
    py = longint'(p.point_y);
    pz = longint'(p.point_z);
    w = dot_row(3, px, py, pz);
    r.out_x = saturating_divide(dot_row(0, px, py, pz), w);
    r.out_y = saturating_divide(dot_row(1, px, py, pz), w);
    r.out_z = saturating_divide(dot_row(2, px, py, pz), w);
    r.zero_w = (w == 0);
    return r;
  endfunction

  // result checker
  always @(posedge clk) begin
    hpt_out_t exp_pt;
    if (rst_n && out_strobe) begin
      if (expected_points.size() == 0) begin
        $display("%0t: unexpected result %h", $time, out_result);
        fail_count++;
      end else begin
        exp_pt = expected_points.pop_front();
        if (out_result.out_x !== exp_pt.out_x) begin
          $display("%0t: out_x expected %h actual %h", $time, exp_pt.out_x, out_result.out_x);
          fail_count++;
        end
        if (out_result.out_y !== exp_pt.out_y) begin
          $display("%0t: out_y expected %h actual %h", $time, exp_pt.out_y, out_result.out_y);
          fail_count++;
        end
        if (out_result.out_z !== exp_pt.out_z) begin
          $display("%0t: out_z expected %h actual %h", $time, exp_pt.out_z, out_result.out_z);
          fail_count++;
        end
        if (out_result.zero_w !== exp_pt.zero_w) begin
          $display("%0t: zero_w expected %b actual %b", $time, exp_pt.zero_w,
                   out_result.zero_w);
          fail_count++;
        end
      end
    end
  end

  // watchdog on cycles with no beat
  always @(posedge clk) begin
    if ((start && !busy) || out_strobe || psel) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG) begin
      $display("homogeneous_point_transform regression: fail");
      $finish;
    end
  end

  task automatic write_matrix_reg(logic [2:0] idx, logic [CFG_W-1:0] val);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_W'(idx) << 3;
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    matrix_regs[idx] = val;
  endtask

  // single point beat, with random idle gaps before it outside dense mode
  task automatic send_point(hpt_in_t p);
    if (!dense_mode) begin
      while ($urandom_range(99) < 34) begin
        start <= 1'b0;
        @(posedge clk);
      end
    end
    start <= 1'b1;
    in_point <= p;
    do @(posedge clk); while (busy);
    expected_points = {expected_points, transform_point(p)};
  endtask

  task automatic drain_results();
    int n;
    n = 0;
    start <= 1'b0;
    while (expected_points.size() != 0 && n < 4 * LATENCY + 100) begin
      @(posedge clk);
      n++;
    end
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(5))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return 32'($signed($urandom_range(65536 * 8)) - 65536 * 4);
      3: return 32'($signed($urandom_range(256)) - 128);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] rand_entry();
    case ($urandom_range(5))
      0: return 32'h00010000;
      1: return 32'h0;
      2: return 32'($signed($urandom_range(65536 * 4)) - 65536 * 2);
      3: return $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
      default: return $urandom;
    endcase
  endfunction

  task automatic test_identity_extremes();
    hpt_in_t p;
    logic [31:0] vals [6] = '{32'h0, 32'h00010000, 32'hffff0000, 32'h7fffffff,
                              32'h80000000, 32'h00000001};
    foreach (vals[i]) begin
      p.point_x = vals[i];
      p.point_y = vals[(i + 1) % 6];
      p.point_z = vals[(i + 2) % 6];
      send_point(p);
    end
    drain_results();
  endtask

  task automatic test_zero_w();
    hpt_in_t p;
    // w row all zero: every point hits the zero-w case, with numerators of both signs
    write_matrix_reg(REG_ROW3_C01, 64'h0);
    write_matrix_reg(REG_ROW3_C23, 64'h0);
    for (int i = 0; i < 6; i++) begin
      p.point_x = (i == 0) ? 32'h0 : rand_coord();
      p.point_y = (i == 0) ? 32'h0 : rand_coord();
      p.point_z = rand_coord();
      send_point(p);
    end
    drain_results();
  endtask

  task automatic test_extreme_matrix();
    hpt_in_t p;
    // largest and most negative entries with tiny w: overflow saturation
    write_matrix_reg(REG_ROW0_C01, {32'h80000000, 32'h7fffffff});
    write_matrix_reg(REG_ROW0_C23, {32'h7fffffff, 32'h80000000});
    write_matrix_reg(REG_ROW1_C01, 64'hffffffff_ffffffff);
    write_matrix_reg(REG_ROW1_C23, 64'h7fffffff_7fffffff);
    write_matrix_reg(REG_ROW2_C01, 64'h80000000_80000000);
    write_matrix_reg(REG_ROW2_C23, 64'h00000000_00010000);
    write_matrix_reg(REG_ROW3_C01, 64'h0);
    write_matrix_reg(REG_ROW3_C23, 64'hffffffff_00000000);
    for (int i = 0; i < 8; i++) begin
      p.point_x = rand_coord();
      p.point_y = rand_coord();
      p.point_z = rand_coord();
      send_point(p);
    end
    drain_results();
  endtask

  task automatic test_random_points();
    hpt_in_t p;
    for (int phase = 0; phase < 6; phase++) begin
      for (int r = 0; r < NUM_REGS; r++)
        write_matrix_reg(3'(r), {rand_entry(), rand_entry()});
      // a perspective-style w row in even phases sets the constant w term to one
      if (phase % 2 == 0)
        write_matrix_reg(REG_ROW3_C23, {32'h00010000, rand_entry()});
      dense_mode = (phase == 3);
      for (int i = 0; i < RAND_ITEMS / 6; i++) begin
        p.point_x = rand_coord();
        p.point_y = rand_coord();
        p.point_z = rand_coord();
        send_point(p);
      end
      dense_mode = 1'b0;
      drain_results();
    end
  endtask

  initial begin
    fail_count = 0;
    idle_cycles = 0;
    dense_mode = 1'b0;
    rst_n = 1'b0;
    start = 1'b0;
    in_point = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    for (int r = 0; r < NUM_REGS; r++) matrix_regs[r] = '0;
    matrix_regs[REG_ROW0_C01] = 64'h0000_0000_0001_0000;
    matrix_regs[REG_ROW1_C01] = 64'h0001_0000_0000_0000;
    matrix_regs[REG_ROW2_C23] = 64'h0000_0000_0001_0000;
    matrix_regs[REG_ROW3_C23] = 64'h0001_0000_0000_0000;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    test_identity_extremes();
    test_zero_w();
    test_extreme_matrix();
    test_random_points();

    if (fail_count == 0 && expected_points.size() == 0) begin
      $display("homogeneous_point_transform regression: pass");
    end else begin
      $display("homogeneous_point_transform regression: fail");
    end
    $finish;
  end

endmodule
`default_nettype wire
